[rtl/tskf_pkg.sv]
// ----------------------------------------------------------------------------
// tskf_pkg
// Shared types, constants and fixed-point helpers for the two-state filter.
// ----------------------------------------------------------------------------
package tskf_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DT_W      = 16;
    localparam int NOISE_W   = 31;
    localparam int MAG_W     = DATA_W + FRAC_BITS;
    localparam int CNT_W     = $clog2(MAG_W);

    localparam logic [NOISE_W-1:0] VALUE_NOISE_RST  = NOISE_W'(66);
    localparam logic [NOISE_W-1:0] BIAS_NOISE_RST   = NOISE_W'(197);
    localparam logic [NOISE_W-1:0] SENSOR_NOISE_RST = NOISE_W'(1966);

    localparam logic signed [DATA_W-1:0] MAXV = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MINV = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REG_VALUE_NOISE  = 2'd0,
        REG_BIAS_NOISE   = 2'd1,
        REG_SENSOR_NOISE = 2'd2
    } reg_index_t;

    localparam logic ACT_RESTART = 1'b0;

    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] measured_value;
        logic signed [DATA_W-1:0] measured_rate;
        logic [DT_W-1:0]          time_step;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] estimated_value;
        logic signed [DATA_W-1:0] corrected_rate;
        logic signed [DATA_W-1:0] estimated_bias;
    } out_t;

    function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] a);
        logic [DATA_W-1:0] r;
        r = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] from_mag(input logic neg,
                                                          input logic [MAG_W-1:0] m);
        logic [MAG_W-1:0]         lim;
        logic signed [DATA_W-1:0] r;
        lim = neg ? MAG_W'({1'b1, {(DATA_W-1){1'b0}}}) : MAG_W'(MAXV);
        if (m > lim)
            r = neg ? MINV : MAXV;
        else if (neg)
            r = DATA_W'(-m[DATA_W-1:0]);
        else
            r = m[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b,
                                                         input logic sub);
        logic signed [DATA_W:0]   s;
        logic signed [DATA_W-1:0] r;
        if (sub)
            s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        else
            s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
            r = s[DATA_W] ? MINV : MAXV;
        else
            r = s[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] mul_q(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        logic [2*DATA_W-1:0] p;
        p = mag(a) * mag(b);
        return from_mag(a[DATA_W-1] ^ b[DATA_W-1], p[2*DATA_W-1:FRAC_BITS]);
    endfunction

endpackage

[rtl/tskf_div.sv]
// ----------------------------------------------------------------------------
// tskf_div
// Restoring divider, one quotient bit per cycle: (n << FRAC_BITS) / d.
// ----------------------------------------------------------------------------
module tskf_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic signed [tskf_pkg::DATA_W-1:0] numer,
    input  logic signed [tskf_pkg::DATA_W-1:0] denom,
    output logic                           done,
    output logic signed [tskf_pkg::DATA_W-1:0] quot
);
    import tskf_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MAG_W-1:0]  num_reg, num_next;
    logic [MAG_W-1:0]  q_reg, q_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dv_reg, dv_next;
    logic              neg_reg, neg_next;
    logic              zero_reg, zero_next;
    logic [DATA_W:0]   rem_sh;
    logic              qbit;

    always_comb
    begin
        rem_sh    = {rem_reg, num_reg[MAG_W-1]};
        qbit      = rem_sh >= {1'b0, dv_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dv_next   = dv_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = {mag(numer), {FRAC_BITS{1'b0}}};
            q_next    = '0;
            rem_next  = '0;
            dv_next   = mag(denom);
            neg_next  = numer[DATA_W-1] ^ denom[DATA_W-1];
            zero_next = denom == '0;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? DATA_W'(rem_sh - {1'b0, dv_reg}) : rem_sh[DATA_W-1:0];
            q_next   = {q_reg[MAG_W-2:0], qbit};
            num_next = {num_reg[MAG_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dv_reg   <= dv_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    assign done = done_reg;
    assign quot = zero_reg ? '0 : from_mag(neg_reg, q_reg);

endmodule

[rtl/two_state_kalman_filter.sv]
// ----------------------------------------------------------------------------
// two_state_kalman_filter
// Value and rate-bias Kalman filter in saturating signed Q16.16.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready with in_data; each gives one result on
// out_valid/out_ready with out_data. action 0 restarts the filter at the
// measured value; action 1 predicts and corrects.
// in_ready is high only while the sequencer is idle. A restart goes from
// acceptance straight to the final step, which loads the output register; an
// update runs through one shared saturating adder, one 32x32 multiplier and
// two bit-serial divisions for the gains. No request is taken before the last
// one has reached the output register. The next request is taken as soon as
// the result sits in the output register, so a stalled receiver holds back
// at most one further result: the sequencer waits in its final step until
// the output register is free.
// Noise registers are written on cfg_valid/cfg_ready by index (0 value noise,
// 1 bias noise, 2 sensor noise); cfg_ready is always high; other indexes are
// dropped. Write them only while idle.
// Reset clears the estimates and covariance and loads the default noise values.
// ----------------------------------------------------------------------------
module two_state_kalman_filter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tskf_pkg::in_t         in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tskf_pkg::out_t        out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [tskf_pkg::DATA_W-1:0] cfg_data
);
    import tskf_pkg::*;

    typedef enum logic [32:0] {
        ST_IDLE = 33'd1 << 0,
        ST_RATE = 33'd1 << 1,
        ST_M1   = 33'd1 << 2,
        ST_A1   = 33'd1 << 3,
        ST_M2   = 33'd1 << 4,
        ST_A2   = 33'd1 << 5,
        ST_A3   = 33'd1 << 6,
        ST_A4   = 33'd1 << 7,
        ST_M3   = 33'd1 << 8,
        ST_A5   = 33'd1 << 9,
        ST_A6   = 33'd1 << 10,
        ST_A7   = 33'd1 << 11,
        ST_M4   = 33'd1 << 12,
        ST_A8   = 33'd1 << 13,
        ST_A9   = 33'd1 << 14,
        ST_DS0  = 33'd1 << 15,
        ST_DW0  = 33'd1 << 16,
        ST_DS1  = 33'd1 << 17,
        ST_DW1  = 33'd1 << 18,
        ST_A10  = 33'd1 << 19,
        ST_M5   = 33'd1 << 20,
        ST_A11  = 33'd1 << 21,
        ST_M6   = 33'd1 << 22,
        ST_A12  = 33'd1 << 23,
        ST_M7   = 33'd1 << 24,
        ST_A13  = 33'd1 << 25,
        ST_M8   = 33'd1 << 26,
        ST_A14  = 33'd1 << 27,
        ST_M9   = 33'd1 << 28,
        ST_A15  = 33'd1 << 29,
        ST_M10  = 33'd1 << 30,
        ST_A16  = 33'd1 << 31,
        ST_DONE = 33'd1 << 32
    } state_t;

    typedef logic signed [DATA_W-1:0] data_t;

    state_t state_reg, state_next;
    logic [NOISE_W-1:0] qv_reg, qb_reg, rn_reg;
    data_t ve_reg, bias_reg, c00_reg, c01_reg, c10_reg, c11_reg;
    data_t mv_reg, mr_reg, rate_reg, t_reg, acc_reg, s_reg, k0_reg, k1_reg, dv_reg, prod_reg;
    logic [DT_W-1:0] dt_reg;
    logic  out_valid_reg;
    out_t  out_data_reg;

    data_t alu_a, alu_b, alu_res, mul_a, mul_b, mul_res, dt_s;
    logic  alu_sub;
    logic  in_acc, out_free, div_start, div_done;
    data_t div_numer, div_quot;

    assign in_ready  = state_reg == ST_IDLE;
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign dt_s      = DATA_W'({1'b0, dt_reg});
    assign div_start = state_reg == ST_DS0 || state_reg == ST_DS1;
    assign div_numer = state_reg == ST_DS0 ? c00_reg : c10_reg;

    tskf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (s_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        alu_a   = ve_reg;
        alu_b   = prod_reg;
        alu_sub = 1'b0;
        mul_a   = rate_reg;
        mul_b   = dt_s;
        case (state_reg)
            ST_RATE: begin alu_a = mr_reg;  alu_b = bias_reg; alu_sub = 1'b1; end
            ST_A2:   begin alu_a = t_reg;   alu_b = c01_reg;  alu_sub = 1'b1; end
            ST_A3:   begin alu_a = acc_reg; alu_b = c10_reg;  alu_sub = 1'b1; end
            ST_A4:   begin alu_a = acc_reg; alu_b = DATA_W'({1'b0, qv_reg}); end
            ST_A5:   begin alu_a = c00_reg; end
            ST_A6:   begin alu_a = c01_reg; alu_b = t_reg;    alu_sub = 1'b1; end
            ST_A7:   begin alu_a = c10_reg; alu_b = t_reg;    alu_sub = 1'b1; end
            ST_A8:   begin alu_a = c11_reg; end
            ST_A9:   begin alu_a = c00_reg; alu_b = DATA_W'({1'b0, rn_reg}); end
            ST_A10:  begin alu_a = mv_reg;  alu_b = ve_reg;   alu_sub = 1'b1; end
            ST_A12:  begin alu_a = bias_reg; end
            ST_A13:  begin alu_a = c10_reg; alu_sub = 1'b1; end
            ST_A14:  begin alu_a = c00_reg; alu_sub = 1'b1; end
            ST_A15:  begin alu_a = c11_reg; alu_sub = 1'b1; end
            ST_A16:  begin alu_a = c01_reg; alu_sub = 1'b1; end
            default: ;
        endcase
        case (state_reg)
            ST_M2:   mul_a = c11_reg;
            ST_M3:   mul_a = acc_reg;
            ST_M4:   mul_a = DATA_W'({1'b0, qb_reg});
            ST_M5:   begin mul_a = k0_reg; mul_b = dv_reg;  end
            ST_M6:   begin mul_a = k1_reg; mul_b = dv_reg;  end
            ST_M7:   begin mul_a = k1_reg; mul_b = c00_reg; end
            ST_M8:   begin mul_a = k0_reg; mul_b = c00_reg; end
            ST_M9:   begin mul_a = k1_reg; mul_b = c01_reg; end
            ST_M10:  begin mul_a = k0_reg; mul_b = c01_reg; end
            default: ;
        endcase
        alu_res = sat_add(alu_a, alu_b, alu_sub);
        mul_res = mul_q(mul_a, mul_b);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_acc)
                         state_next = in_data.action == ACT_RESTART ? ST_DONE : ST_RATE;
            ST_RATE: state_next = ST_M1;
            ST_M1:   state_next = ST_A1;
            ST_A1:   state_next = ST_M2;
            ST_M2:   state_next = ST_A2;
            ST_A2:   state_next = ST_A3;
            ST_A3:   state_next = ST_A4;
            ST_A4:   state_next = ST_M3;
            ST_M3:   state_next = ST_A5;
            ST_A5:   state_next = ST_A6;
            ST_A6:   state_next = ST_A7;
            ST_A7:   state_next = ST_M4;
            ST_M4:   state_next = ST_A8;
            ST_A8:   state_next = ST_A9;
            ST_A9:   state_next = ST_DS0;
            ST_DS0:  state_next = ST_DW0;
            ST_DW0:  if (div_done) state_next = ST_DS1;
            ST_DS1:  state_next = ST_DW1;
            ST_DW1:  if (div_done) state_next = ST_A10;
            ST_A10:  state_next = ST_M5;
            ST_M5:   state_next = ST_A11;
            ST_A11:  state_next = ST_M6;
            ST_M6:   state_next = ST_A12;
            ST_A12:  state_next = ST_M7;
            ST_M7:   state_next = ST_A13;
            ST_A13:  state_next = ST_M8;
            ST_M8:   state_next = ST_A14;
            ST_A14:  state_next = ST_M9;
            ST_M9:   state_next = ST_A15;
            ST_A15:  state_next = ST_M10;
            ST_M10:  state_next = ST_A16;
            ST_A16:  state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            qv_reg        <= VALUE_NOISE_RST;
            qb_reg        <= BIAS_NOISE_RST;
            rn_reg        <= SENSOR_NOISE_RST;
            ve_reg        <= '0;
            bias_reg      <= '0;
            c00_reg       <= '0;
            c01_reg       <= '0;
            c10_reg       <= '0;
            c11_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_VALUE_NOISE:  qv_reg <= cfg_data[NOISE_W-1:0];
                    REG_BIAS_NOISE:   qb_reg <= cfg_data[NOISE_W-1:0];
                    REG_SENSOR_NOISE: rn_reg <= cfg_data[NOISE_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (in_acc && in_data.action == ACT_RESTART)
            begin
                ve_reg   <= in_data.measured_value;
                bias_reg <= '0;
                c00_reg  <= '0;
                c01_reg  <= '0;
                c10_reg  <= '0;
                c11_reg  <= '0;
            end
            case (state_reg)
                ST_A1, ST_A11:  ve_reg   <= alu_res;
                ST_A12:         bias_reg <= alu_res;
                ST_A5, ST_A14:  c00_reg  <= alu_res;
                ST_A6, ST_A16:  c01_reg  <= alu_res;
                ST_A7, ST_A13:  c10_reg  <= alu_res;
                ST_A8, ST_A15:  c11_reg  <= alu_res;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mv_reg   <= in_data.measured_value;
            mr_reg   <= in_data.measured_rate;
            dt_reg   <= in_data.time_step;
            rate_reg <= in_data.measured_rate;
        end
        case (state_reg)
            ST_RATE:              rate_reg <= alu_res;
            ST_M2:                t_reg    <= mul_res;
            ST_A2, ST_A3, ST_A4:  acc_reg  <= alu_res;
            ST_A9:                s_reg    <= alu_res;
            ST_A10:               dv_reg   <= alu_res;
            ST_DW0:               if (div_done) k0_reg <= div_quot;
            ST_DW1:               if (div_done) k1_reg <= div_quot;
            default: ;
        endcase
        prod_reg <= mul_res;
        if (state_reg == ST_DONE && out_free)
        begin
            out_data_reg.estimated_value <= ve_reg;
            out_data_reg.corrected_rate  <= rate_reg;
            out_data_reg.estimated_bias  <= bias_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DW0 || state_reg == ST_DW1))
        else $error("division finished outside a wait step");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_data.action == ACT_RESTART) |=>
        (bias_reg == '0 && c00_reg == '0 && c11_reg == '0 && state_reg == ST_DONE))
        else $error("restart did not clear the filter state");

    a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !out_free) |=> state_reg == ST_DONE)
        else $error("result left the sequencer while output register was full");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-state value and bias Kalman filter: a
// queue-fed driver offers restart and update requests, a fixed-point
// predictor works out each expected estimate, and a monitor compares every
// result field by field under random idling, a long receiver hold-off and
// several noise register settings, extremes included.
// ----------------------------------------------------------------------------
module tb;
    import tskf_pkg::*;

    localparam logic ACT_UPDATE = ~ACT_RESTART;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid;
    logic in_ready;
    in_t in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;

    in_t pending[$];
    out_t estimate_q[$];
    int send_idle = 24;
    int recv_idle = 55;
    logic hold_off = 1'b0;
    int n_accepted = 0;
    int n_restart = 0;
    int n_update = 0;
    int n_checked = 0;
    int n_errors = 0;

    longint est_value, est_bias, p00, p01, p10, p11;
    longint q_value, q_bias, r_sensor;

    two_state_kalman_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint clip(input longint v);
        return (v > QMAX) ? QMAX : (v < QMIN) ? QMIN : v;
    endfunction

    function automatic longint unsigned magn(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint qmul(input longint a, input longint b, input int sh);
        longint unsigned m;
        m = (magn(a) * magn(b)) >> sh;
        return ((a < 0) != (b < 0)) ? clip(-longint'(m)) : clip(longint'(m));
    endfunction

    function automatic longint qdiv(input longint n, input longint d);
        longint unsigned m;
        if (d == 0)
            return 0;
        m = (magn(n) << FRAC_BITS) / magn(d);
        return ((n < 0) != (d < 0)) ? clip(-longint'(m)) : clip(longint'(m));
    endfunction

    function automatic out_t filter_step(input in_t req);
        longint mv, mr, dt, rate, t, s, k0, k1, dv, old00, old01;
        out_t res;
        mv = longint'(req.measured_value);
        mr = longint'(req.measured_rate);
        dt = longint'(req.time_step);
        if (req.action == ACT_RESTART)
        begin
            est_value = mv;
            est_bias = 0;
            p00 = 0;
            p01 = 0;
            p10 = 0;
            p11 = 0;
            rate = mr;
        end
        else
        begin
            rate = clip(mr - est_bias);
            est_value = clip(est_value + qmul(rate, dt, DT_W));
            t = qmul(p11, dt, DT_W);
            p00 = clip(p00 + qmul(clip(clip(clip(t - p01) - p10) + q_value), dt, DT_W));
            p01 = clip(p01 - t);
            p10 = clip(p10 - t);
            p11 = clip(p11 + qmul(q_bias, dt, DT_W));
            s = clip(p00 + r_sensor);
            k0 = qdiv(p00, s);
            k1 = qdiv(p10, s);
            dv = clip(mv - est_value);
            est_value = clip(est_value + qmul(k0, dv, FRAC_BITS));
            est_bias = clip(est_bias + qmul(k1, dv, FRAC_BITS));
            old00 = p00;
            old01 = p01;
            p00 = clip(p00 - qmul(k0, old00, FRAC_BITS));
            p01 = clip(p01 - qmul(k0, old01, FRAC_BITS));
            p10 = clip(p10 - qmul(k1, old00, FRAC_BITS));
            p11 = clip(p11 - qmul(k1, old01, FRAC_BITS));
        end
        res.estimated_value = est_value[DATA_W-1:0];
        res.corrected_rate = rate[DATA_W-1:0];
        res.estimated_bias = est_bias[DATA_W-1:0];
        return res;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            est_value = 0;
            est_bias = 0;
            p00 = 0;
            p01 = 0;
            p10 = 0;
            p11 = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                estimate_q.push_back(filter_step(in_data));
                n_accepted++;
                if (in_data.action == ACT_RESTART)
                    n_restart++;
                else
                    n_update++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    in_data <= pending.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_value = longint'(VALUE_NOISE_RST);
            q_bias = longint'(BIAS_NOISE_RST);
            r_sensor = longint'(SENSOR_NOISE_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_VALUE_NOISE:  q_value = longint'(cfg_data[NOISE_W-1:0]);
                REG_BIAS_NOISE:   q_bias = longint'(cfg_data[NOISE_W-1:0]);
                REG_SENSOR_NOISE: r_sensor = longint'(cfg_data[NOISE_W-1:0]);
                default: ;
            endcase
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (estimate_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    n_errors++;
                end
                else
                begin
                    want = estimate_q.pop_front();
                    n_checked++;
                    if (out_data.estimated_value !== want.estimated_value)
                    begin
                        $error("estimated_value expected %0d got %0d",
                               want.estimated_value, out_data.estimated_value);
                        n_errors++;
                    end
                    if (out_data.corrected_rate !== want.corrected_rate)
                    begin
                        $error("corrected_rate expected %0d got %0d",
                               want.corrected_rate, out_data.corrected_rate);
                        n_errors++;
                    end
                    if (out_data.estimated_bias !== want.estimated_bias)
                    begin
                        $error("estimated_bias expected %0d got %0d",
                               want.estimated_bias, out_data.estimated_bias);
                        n_errors++;
                    end
                end
            end
            out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
        end
    end

    // long receiver hold-off so the block fills and stalls its input
    initial
    begin
        wait (n_accepted >= 150);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (2500) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [NOISE_W-1:0] v);
        cfg_index <= idx;
        cfg_data <= {1'b0, v};
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending.size() > 0 || in_valid || estimate_q.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic in_t mk_req(input logic act, input int mv, input int mr,
                                   input int dt);
        in_t r;
        r.action = act;
        r.measured_value = mv;
        r.measured_rate = mr;
        r.time_step = dt[DT_W-1:0];
        return r;
    endfunction

    function automatic in_t rand_req();
        logic act;
        act = ($urandom_range(99) < 8) ? ACT_RESTART : ACT_UPDATE;
        if ($urandom_range(99) < 75)
            return mk_req(act, int'($urandom_range(2000000)) - 1000000,
                          int'($urandom_range(200000)) - 100000,
                          $urandom_range(6554));
        return mk_req(act, $urandom, $urandom, $urandom_range(65535));
    endfunction

    initial
    begin
        int p;
        logic [NOISE_W-1:0] rn;
        cfg_valid = 1'b0;
        cfg_index = REG_VALUE_NOISE;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pending.push_back(mk_req(ACT_RESTART, 32'h7FFFFFFF, 32'h80000000, 0));
        pending.push_back(mk_req(ACT_UPDATE, 32'h7FFFFFFF, 32'h7FFFFFFF, 65535));
        pending.push_back(mk_req(ACT_UPDATE, 32'h80000000, 32'h80000000, 65535));
        pending.push_back(mk_req(ACT_UPDATE, 0, 0, 0));
        pending.push_back(mk_req(ACT_RESTART, 32'h80000000, 32'h7FFFFFFF, 65535));
        pending.push_back(mk_req(ACT_UPDATE, 32'h7FFFFFFF, 32'h80000000, 1));
        pending.push_back(mk_req(ACT_RESTART, 0, 0, 0));
        for (int i = 0; i < 8; i++)
            pending.push_back(mk_req(ACT_UPDATE, 65536 * i, 1000, 655));
        pending.push_back(mk_req(ACT_UPDATE, -65536, -1, 65535));
        pending.push_back(mk_req(ACT_UPDATE, 1, 32'h7FFFFFFF, 32768));
        pending.push_back(mk_req(ACT_RESTART, -1, -1, 65535));
        wait_idle();

        for (p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(REG_VALUE_NOISE, '0);
                    write_reg(REG_BIAS_NOISE, '0);
                    write_reg(REG_SENSOR_NOISE, NOISE_W'(1));
                    write_reg(REG_UNUSED, '1);
                end
                1:
                begin
                    send_idle = 55;
                    recv_idle = 24;
                    write_reg(REG_VALUE_NOISE, '1);
                    write_reg(REG_BIAS_NOISE, '1);
                    write_reg(REG_SENSOR_NOISE, '1);
                end
                2:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                    rn = NOISE_W'($urandom_range(1 << 20));
                    write_reg(REG_VALUE_NOISE, NOISE_W'($urandom_range(1 << 18)));
                    write_reg(REG_BIAS_NOISE, NOISE_W'($urandom_range(1 << 18)));
                    write_reg(REG_SENSOR_NOISE, (rn == 0) ? NOISE_W'(1) : rn);
                end
                default:
                begin
                    write_reg(REG_VALUE_NOISE, VALUE_NOISE_RST);
                    write_reg(REG_BIAS_NOISE, BIAS_NOISE_RST);
                    write_reg(REG_SENSOR_NOISE, SENSOR_NOISE_RST);
                end
            endcase
            for (int i = 0; i < 283; i++)
                pending.push_back(rand_req());
            wait_idle();
        end

        $display("covered %0d restarts and %0d updates, %0d results checked,",
                 n_restart, n_update, n_checked);
        $display("over four noise settings with idling, back-pressure and a long hold-off");
        if (n_errors == 0 && estimate_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
